@@ rtl/pcshp_pkg.sv @@
`default_nettype none
package pcshp_pkg;

    localparam int BINS      = 4096;
    localparam int RES_SHIFT = 3;
    localparam int IDX_W     = $clog2(BINS);
    localparam int CNT_W     = 32;
    localparam int PC_W      = 32;
    localparam int RIDX_W    = 12;
    localparam int KIND_W    = 3;
    localparam int CFG_IDX_W = 2;

    // s_tdata: sample_pc, saved_pc, read_index, zero fill to bytes
    localparam int S_DATA_W = ((2 * PC_W + RIDX_W + 7) / 8) * 8;
    localparam int M_DATA_W = CNT_W;

    localparam logic [KIND_W-1:0] KIND_TICK        = 3'd0;
    localparam logic [KIND_W-1:0] KIND_READ        = 3'd1;
    localparam logic [KIND_W-1:0] KIND_START       = 3'd2;
    localparam logic [KIND_W-1:0] KIND_START_CLEAR = 3'd3;
    localparam logic [KIND_W-1:0] KIND_STOP        = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_PC   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PC   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPL_LOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPL_HIGH = 2'd3;

    localparam logic [IDX_W-1:0] IDX_TOTAL = IDX_W'(0);
    localparam logic [IDX_W-1:0] IDX_OTHER = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(BINS - 1);

endpackage
`default_nettype wire

@@ rtl/pc_sample_histogram_profiler.sv @@
`default_nettype none
// channel | dir | tvalid/tready     | tdata / tuser (low bit first)
// s       | in  | s_tvalid/s_tready | tdata: sample_pc, saved_pc, read_index; tuser: kind
// m       | out | m_tvalid/m_tready | tdata: count; tuser: valid_res
// cfg     | in  | cfg_we            | cfg_index selects register, cfg_wdata is the value
//
// Items are taken one at a time. A sample tick while running makes two read-modify-write
// passes through the counter RAM, which has one read and one write port: total, then bin;
// a tick while stopped, a read, a start/stop or an unused kind goes straight to the result.
// Start-and-clear sweeps all 4096 bins of the RAM to zero, then returns a result.
// After reset the same sweep runs with s_tready low.
// A held result in the output register stalls the block only when the next result is ready.
module pc_sample_histogram_profiler
    import pcshp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_DATA_W-1:0]  s_tdata,   // sample_pc, saved_pc, read_index
    input  wire logic [KIND_W-1:0]    s_tuser,   // kind
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_DATA_W-1:0]       m_tdata,   // count
    output logic [0:0]                m_tuser,   // valid_res
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [PC_W-1:0]      cfg_wdata
);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_TOTAL = 6'b000100,
        ST_RDBIN = 6'b001000,
        ST_WRBIN = 6'b010000,
        ST_RES   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [PC_W-1:0]  min_pc_reg, max_pc_reg, spl_low_reg, spl_high_reg;
    logic             running_reg, running_next;
    logic             clr_cmd_reg, clr_cmd_next;
    logic [IDX_W-1:0] clr_addr_reg, clr_addr_next;
    logic [PC_W-1:0]  pc_eff_reg;
    logic [IDX_W-1:0] tgt_reg;
    logic             read_ok_reg;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [CNT_W-1:0] m_count_reg;
    logic             m_flag_reg;

    logic [CNT_W-1:0] counts_mem [BINS];
    logic [CNT_W-1:0] mem_rdata_reg;
    logic             mem_re, mem_we;
    logic [IDX_W-1:0] mem_ra, mem_wa;
    logic [CNT_W-1:0] mem_wd;

    logic [PC_W-1:0]   in_sample_pc, in_saved_pc, pc_eff, pc_diff, pc_bin;
    logic [RIDX_W-1:0] in_read_index;
    logic              in_accept, in_window, in_range, bin_ok, res_load;
    logic [IDX_W-1:0]  tgt_next;

    assign in_sample_pc  = s_tdata[PC_W-1:0];
    assign in_saved_pc   = s_tdata[2*PC_W-1:PC_W];
    assign in_read_index = s_tdata[2*PC_W+RIDX_W-1:2*PC_W];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    assign in_window = (in_sample_pc >= spl_low_reg) && (in_sample_pc <= spl_high_reg);
    assign pc_eff    = in_window ? in_saved_pc : in_sample_pc;

    // bin selection on the registered pc
    assign in_range = (min_pc_reg <= pc_eff_reg) && (pc_eff_reg < max_pc_reg);
    assign pc_diff  = pc_eff_reg - min_pc_reg;
    assign pc_bin   = pc_diff >> RES_SHIFT;
    assign bin_ok   = in_range && (pc_bin < PC_W'(BINS));
    assign tgt_next = bin_ok ? IDX_W'(pc_bin) : IDX_OTHER;

    assign res_load = (state_reg == ST_RES) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        state_next    = state_reg;
        running_next  = running_reg;
        clr_cmd_next  = clr_cmd_reg;
        clr_addr_next = clr_addr_reg;
        mem_re        = 1'b0;
        mem_ra        = IDX_TOTAL;
        mem_we        = 1'b0;
        mem_wa        = IDX_TOTAL;
        mem_wd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_wa        = clr_addr_reg;
                clr_addr_next = clr_addr_reg + IDX_W'(1);
                if (clr_addr_reg == IDX_LAST)
                begin
                    state_next   = clr_cmd_reg ? ST_RES : ST_IDLE;
                    clr_cmd_next = 1'b0;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    mem_re = 1'b1;
                    mem_ra = (s_tuser == KIND_TICK) ? IDX_TOTAL : IDX_W'(in_read_index);
                    state_next = ST_RES;
                    if (s_tuser == KIND_TICK && running_reg)
                        state_next = ST_TOTAL;
                    if (s_tuser == KIND_START)
                        running_next = 1'b1;
                    if (s_tuser == KIND_STOP)
                        running_next = 1'b0;
                    if (s_tuser == KIND_START_CLEAR)
                    begin
                        running_next  = 1'b1;
                        clr_cmd_next  = 1'b1;
                        clr_addr_next = '0;
                        state_next    = ST_CLEAR;
                    end
                end
            end
            ST_TOTAL:
            begin
                mem_we     = 1'b1;
                mem_wa     = IDX_TOTAL;
                mem_wd     = mem_rdata_reg + CNT_W'(1);
                state_next = ST_RDBIN;
            end
            ST_RDBIN:
            begin
                // total was written last cycle, so a bin 0 read sees it
                mem_re     = 1'b1;
                mem_ra     = tgt_reg;
                state_next = ST_WRBIN;
            end
            ST_WRBIN:
            begin
                mem_we     = 1'b1;
                mem_wa     = tgt_reg;
                mem_wd     = mem_rdata_reg + CNT_W'(1);
                state_next = ST_RES;
            end
            ST_RES:
            begin
                if (res_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (res_load)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            running_reg  <= 1'b0;
            clr_cmd_reg  <= 1'b0;
            clr_addr_reg <= '0;
            m_tvalid_reg <= 1'b0;
            min_pc_reg   <= PC_W'(0);
            max_pc_reg   <= PC_W'(0);
            spl_low_reg  <= PC_W'(1);
            spl_high_reg <= PC_W'(0);
        end
        else
        begin
            state_reg    <= state_next;
            running_reg  <= running_next;
            clr_cmd_reg  <= clr_cmd_next;
            clr_addr_reg <= clr_addr_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MIN_PC:   min_pc_reg   <= cfg_wdata;
                    REG_MAX_PC:   max_pc_reg   <= cfg_wdata;
                    REG_SPL_LOW:  spl_low_reg  <= cfg_wdata;
                    REG_SPL_HIGH: spl_high_reg <= cfg_wdata;
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pc_eff_reg  <= pc_eff;
            read_ok_reg <= (s_tuser == KIND_READ) &&
                           ({{(PC_W-RIDX_W){1'b0}}, in_read_index} < PC_W'(BINS));
        end
        if (state_reg == ST_TOTAL)
            tgt_reg <= tgt_next;
        if (res_load)
        begin
            m_count_reg <= read_ok_reg ? mem_rdata_reg : '0;
            m_flag_reg  <= read_ok_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            counts_mem[mem_wa] <= mem_wd;
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
            mem_rdata_reg <= counts_mem[mem_ra];
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_count_reg;
    assign m_tuser[0] = m_flag_reg;

endmodule
`default_nettype wire

@@ rtl/pcshp_checker.sv @@
`default_nettype none
module pcshp_checker
    import pcshp_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata,
    input wire logic [0:0]          m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // only a valid read carries a count
    a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("nonzero count without valid_res");

    // one item in flight: a transfer closes the input side
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // idle stays idle until an item arrives
    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready && !s_tvalid |=> s_tready)
        else $error("ready dropped without a transfer");

endmodule

bind pc_sample_histogram_profiler pcshp_checker u_pcshp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

@@ tb/pc_sample_histogram_profiler_checker.sv @@
`default_nettype none
module pc_sample_histogram_profiler_checker
    import pcshp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [S_DATA_W-1:0]  s_tdata,   // sample_pc, saved_pc, read_index
    input  wire logic [KIND_W-1:0]    s_tuser,   // kind
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [M_DATA_W-1:0]  m_tdata,   // count
    input  wire logic [0:0]           m_tuser,   // valid_res
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [PC_W-1:0]      cfg_wdata,
    output int                        mismatches,
    output int                        pending_results
);

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             valid;
    } readout_t;

    logic [PC_W-1:0]  lo_pc;
    logic [PC_W-1:0]  hi_pc;
    logic [PC_W-1:0]  win_lo;
    logic [PC_W-1:0]  win_hi;
    logic             hist_running;
    logic [CNT_W-1:0] hist_bins [BINS];

    readout_t due_readouts[$];
    readout_t want;

    function automatic readout_t profile_step(input logic [KIND_W-1:0] k,
                                              input logic [PC_W-1:0]   pc_in,
                                              input logic [PC_W-1:0]   saved,
                                              input logic [RIDX_W-1:0] ridx);
        readout_t        r;
        logic [PC_W-1:0] pc;
        logic [PC_W-1:0] offs;
        r  = '0;
        pc = pc_in;
        case (k)
            KIND_TICK:
                if (hist_running) begin
                    // lock-release window: attribute the sample to the saved pc
                    if (pc >= win_lo && pc <= win_hi)
                        pc = saved;
                    hist_bins[IDX_TOTAL] = hist_bins[IDX_TOTAL] + CNT_W'(1);
                    if (lo_pc <= pc && pc < hi_pc) begin
                        offs = (pc - lo_pc) >> RES_SHIFT;
                        if (offs < BINS)
                            hist_bins[offs[IDX_W-1:0]] = hist_bins[offs[IDX_W-1:0]] + CNT_W'(1);
                        else
                            hist_bins[IDX_OTHER] = hist_bins[IDX_OTHER] + CNT_W'(1);
                    end
                    else begin
                        hist_bins[IDX_OTHER] = hist_bins[IDX_OTHER] + CNT_W'(1);
                    end
                end
            KIND_READ:
                if (ridx < BINS) begin
                    r.count = hist_bins[ridx];
                    r.valid = 1'b1;
                end
            KIND_START:
                hist_running = 1'b1;
            KIND_START_CLEAR:
            begin
                foreach (hist_bins[i])
                    hist_bins[i] = '0;
                hist_running = 1'b1;
            end
            KIND_STOP:
                hist_running = 1'b0;
            default:
                ;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            lo_pc        = '0;
            hi_pc        = '0;
            win_lo       = 32'd1;
            win_hi       = '0;
            hist_running = 1'b0;
            foreach (hist_bins[i])
                hist_bins[i] = '0;
            due_readouts.delete();
            pending_results <= 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_MIN_PC:   lo_pc  = cfg_wdata;
                    REG_MAX_PC:   hi_pc  = cfg_wdata;
                    REG_SPL_LOW:  win_lo = cfg_wdata;
                    REG_SPL_HIGH: win_hi = cfg_wdata;
                    default:      ;
                endcase
            end
            if (s_tvalid && s_tready)
                due_readouts.push_back(profile_step(s_tuser,
                                                    s_tdata[PC_W-1:0],
                                                    s_tdata[2*PC_W-1:PC_W],
                                                    s_tdata[2*PC_W+RIDX_W-1:2*PC_W]));
            // a result comes out only after its item was taken, so the front is always older
            if (m_tvalid && m_tready) begin
                if (due_readouts.size() == 0) begin
                    $error("unexpected result transfer: count %h valid_res %b",
                           m_tdata, m_tuser);
                    mismatches++;
                end
                else begin
                    want = due_readouts.pop_front();
                    if (m_tdata !== want.count) begin
                        $error("count: expected %h, actual %h", want.count, m_tdata);
                        mismatches++;
                    end
                    if (m_tuser[0] !== want.valid) begin
                        $error("valid_res: expected %b, actual %b", want.valid, m_tuser[0]);
                        mismatches++;
                    end
                end
            end
            pending_results <= due_readouts.size();
        end
    end

endmodule
`default_nettype wire

@@ tb/pc_sample_histogram_profiler_tb.sv @@
`default_nettype none
module pc_sample_histogram_profiler_tb;
    import pcshp_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;   // sample_pc, saved_pc, read_index
    logic [KIND_W-1:0]    s_tuser;   // kind
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;   // count
    logic [0:0]           m_tuser;   // valid_res
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [PC_W-1:0]      cfg_wdata;

    int mismatches;
    int pending_results;

    logic            calm = 1'b0;
    logic [PC_W-1:0] cur_min;
    logic [PC_W-1:0] cur_max;
    logic [PC_W-1:0] cur_wlo;
    logic [PC_W-1:0] cur_whi;
    logic [IDX_W-1:0] hot_bin = '0;
    int              sent = 0;

    pc_sample_histogram_profiler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    pc_sample_histogram_profiler_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .mismatches      (mismatches),
        .pending_results (pending_results)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic send_item(input logic [KIND_W-1:0] k, input logic [PC_W-1:0] pc,
                             input logic [PC_W-1:0] saved, input logic [RIDX_W-1:0] ridx);
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= S_DATA_W'({ridx, saved, pc});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13))
                @(posedge clk);
        end
    endtask

    // hold off until every outstanding result has been returned
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PC_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_profile(input logic [PC_W-1:0] lo, input logic [PC_W-1:0] hi,
                               input logic [PC_W-1:0] wlo, input logic [PC_W-1:0] whi);
        cur_min = lo;
        cur_max = hi;
        cur_wlo = wlo;
        cur_whi = whi;
        write_reg(REG_MIN_PC, lo);
        write_reg(REG_MAX_PC, hi);
        write_reg(REG_SPL_LOW, wlo);
        write_reg(REG_SPL_HIGH, whi);
    endtask

    // pcs cluster near the low bins, the range ends and the lock window
    function automatic logic [PC_W-1:0] pick_pc();
        int              r;
        logic [PC_W-1:0] span;
        r    = $urandom_range(0, 99);
        span = cur_max - cur_min;
        if (r < 40)
            return cur_min + $urandom_range(0, 255);
        else if (r < 55)
            return (span > 1) ? cur_min + $urandom_range(0, span - 1) : cur_min;
        else if (r < 65)
            return cur_max + $urandom_range(0, 16) - 32'd8;
        else if (r < 80)
            return (cur_whi >= cur_wlo) ? cur_wlo + $urandom_range(0, cur_whi - cur_wlo)
                                        : cur_wlo + $urandom_range(0, 15) - 32'd8;
        else
            return $urandom();
    endfunction

    task automatic send_random();
        int               r;
        logic [KIND_W-1:0] k;
        logic [PC_W-1:0]  pc;
        logic [PC_W-1:0]  saved;
        logic [RIDX_W-1:0] ridx;
        logic [PC_W-1:0]  offs;
        r     = $urandom_range(0, 999);
        pc    = pick_pc();
        saved = pick_pc();
        ridx  = RIDX_W'($urandom_range(0, 4095));
        if (r < 560)
            k = KIND_TICK;
        else if (r < 880)
            k = KIND_READ;
        else if (r < 930)
            k = KIND_START;
        else if (r < 950)
            k = KIND_STOP;
        else if (r < 958)
            k = KIND_START_CLEAR;
        else
            k = KIND_STOP + KIND_W'($urandom_range(1, 3));
        if (k == KIND_TICK) begin
            offs    = (pc - cur_min) >> RES_SHIFT;
            hot_bin = offs[IDX_W-1:0];
        end
        else if (k == KIND_READ) begin
            r = $urandom_range(0, 9);
            if (r < 5)
                ridx = RIDX_W'($urandom_range(0, 31));
            else if (r < 7)
                ridx = hot_bin;
        end
        send_item(k, pc, saved, ridx);
    endtask

    initial
    begin
        m_tready = 1'b0;
        @(posedge clk);
        forever begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 25))
                @(posedge clk);
            if (!calm && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13))
                    @(posedge clk);
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = KIND_TICK;
        cfg_we    = 1'b0;
        cfg_index = REG_MIN_PC;
        cfg_wdata = '0;
        cur_min   = '0;
        cur_max   = '0;
        cur_wlo   = 32'd1;
        cur_whi   = '0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: empty range, inverted window
        send_item(KIND_TICK, 32'hFFFF_FFFF, 32'h0, '0);      // stopped, no effect
        send_item(KIND_READ, 32'h0, 32'h0, 12'd0);
        send_item(KIND_STOP + KIND_W'(3), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
        send_item(KIND_START, 32'h0, 32'h0, '0);
        send_item(KIND_TICK, 32'h0, 32'hFFFF_FFFF, '0);
        send_item(KIND_READ, 32'h0, 32'h0, 12'd0);
        send_item(KIND_READ, 32'h0, 32'h0, 12'd1);
        send_item(KIND_READ, 32'h0, 32'h0, 12'hFFF);
        settle();

        // range reaches past the last bin; small lock window
        set_profile(32'h1000, 32'h9040, 32'h2000, 32'h20FF);
        send_item(KIND_TICK, 32'h1000, 32'h0, '0);           // bin 0
        send_item(KIND_TICK, 32'h1008, 32'h0, '0);           // bin 1
        send_item(KIND_TICK, 32'h01F8, 32'h0, '0);           // below range
        send_item(KIND_TICK, 32'h9000, 32'h0, '0);           // bin past store
        send_item(KIND_TICK, 32'h9040, 32'h0, '0);           // at max, excluded
        send_item(KIND_TICK, 32'h2000, 32'h1320, '0);        // window low edge -> bin 100
        send_item(KIND_TICK, 32'h2100, 32'h1320, '0);        // just past window
        send_item(KIND_TICK, 32'h8FF8, 32'h0, '0);           // last bin
        send_item(KIND_READ, 32'h0, 32'h0, 12'd0);
        send_item(KIND_READ, 32'h0, 32'h0, 12'd100);
        send_item(KIND_READ, 32'h0, 32'h0, 12'hFFF);
        send_item(KIND_STOP, 32'h0, 32'h0, '0);
        send_item(KIND_TICK, 32'h1000, 32'h0, '0);
        send_item(KIND_READ, 32'h0, 32'h0, 12'd0);
        send_item(KIND_START_CLEAR, 32'h0, 32'h0, '0);
        send_item(KIND_READ, 32'h0, 32'h0, 12'd100);

        for (int ph = 0; ph < 6; ph++) begin
            settle();
            case (ph)
                0: set_profile(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                1: set_profile(32'h0004_0000, 32'h0004_8100, 32'h0, 32'hFFFF_FFFF);
                2: set_profile(32'h8000_0000, 32'h7FFF_FFF0, 32'h10, 32'h0);
                3: set_profile(32'hFFFF_F000, 32'hFFFF_FFFF, 32'h0, 32'hFF);
                default:
                begin
                    cur_min = $urandom() & 32'hFFFF_FFF8;
                    cur_wlo = $urandom();
                    set_profile(cur_min, cur_min + $urandom_range(8, 40000),
                                cur_wlo, cur_wlo + $urandom_range(0, 4095));
                end
            endcase
            send_item(KIND_START, $urandom(), $urandom(), RIDX_W'($urandom_range(0, 4095)));
            for (int n = 0; n < 215; n++) begin
                if (sent >= 1140)
                    calm = 1'b1;
                send_random();
                sent++;
            end
        end

        settle();
        repeat (20)
            @(posedge clk);
        if (mismatches == 0 && pending_results == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
`default_nettype wire
